/* src/block_chain_allocation_table_defines.svh */
// Assertion macros used by the file that checks its own behaviour.
`ifndef BLOCK_CHAIN_ALLOCATION_TABLE_DEFINES_SVH
`define BLOCK_CHAIN_ALLOCATION_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bct check failed");

// Consequent must hold in the cycle after the antecedent.
`define BCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bct check failed");

`endif

/* src/bct_pkg.sv */
package bct_pkg;

    typedef enum logic [2:0] {
        MODE_ALLOC      = 3'd0,
        MODE_LINK       = 3'd1,
        MODE_MARK_END   = 3'd2,
        MODE_FREE       = 3'd3,
        MODE_FREE_CHAIN = 3'd4,
        MODE_READ       = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_FREE     = 2'd0,
        KIND_END      = 2'd1,
        KIND_RESERVED = 2'd2,
        KIND_LINK     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_EV,
        S_OUT
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  link;
    } t_entry;

endpackage

/* src/bct_table.sv */
module bct_table #(
    parameter int NUM_BLOCKS      = 64,
    parameter int RESERVED_BLOCKS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_wr_addr,
    input  bct_pkg::t_entry               i_wr_data,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_rd_addr,
    output bct_pkg::t_entry               o_rd_data
);

    bct_pkg::t_entry         r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   r_valid;
    bct_pkg::t_entry         r_rd_data;
    logic                    r_rd_valid;
    logic                    r_rd_boot;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_boot  <= int'(i_rd_addr) < RESERVED_BLOCKS;
    end

    // An entry never written since reset still holds its boot value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data.kind = r_rd_boot ? bct_pkg::KIND_RESERVED : bct_pkg::KIND_FREE;
            o_rd_data.link = 6'd0;
        end
    end

endmodule

/* src/bct_ctrl.sv */
module bct_ctrl #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [23:0]                   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [23:0]                   o_m_tdata,
    output logic                          o_wr_en,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_wr_addr,
    output bct_pkg::t_entry               o_wr_data,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_rd_addr,
    input  bct_pkg::t_entry               i_rd_data
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam logic [IW-1:0] LAST = IW'(NUM_BLOCKS - 1);

    bct_pkg::t_state  r_state, n_state;
    bct_pkg::t_mode   r_mode;
    logic [7:0]       r_blk;
    logic [5:0]       r_tgt;
    logic [IW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_step, n_step;
    logic [5:0]       r_res_block, n_res_block;
    bct_pkg::t_kind   r_res_kind, n_res_kind;
    bct_pkg::t_status r_status, n_status;
    logic [6:0]       r_freed, n_freed;

    logic accept;
    logic blk_ok;
    logic tgt_ok;
    logic link_ok;

    assign accept  = i_s_tvalid && (r_state == bct_pkg::S_IDLE);
    assign blk_ok  = int'(r_blk) < NUM_BLOCKS;
    assign tgt_ok  = int'(r_tgt) < NUM_BLOCKS;
    assign link_ok = int'(i_rd_data.link) < NUM_BLOCKS;

    assign o_s_tready = (r_state == bct_pkg::S_IDLE);
    assign o_m_tvalid = (r_state == bct_pkg::S_OUT);
    assign o_m_tdata  = {7'd0, r_freed, r_status, r_res_kind, r_res_block};
    assign o_rd_addr  = r_cur;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bct_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = bct_pkg::S_EXEC;
                end
            end
            bct_pkg::S_EXEC: begin
                case (r_mode)
                    bct_pkg::MODE_ALLOC: n_state = bct_pkg::S_RD;
                    bct_pkg::MODE_FREE_CHAIN,
                    bct_pkg::MODE_READ: n_state = blk_ok ? bct_pkg::S_RD : bct_pkg::S_OUT;
                    default: n_state = bct_pkg::S_OUT;
                endcase
            end
            bct_pkg::S_RD: n_state = bct_pkg::S_EV;
            bct_pkg::S_EV: begin
                case (r_mode)
                    bct_pkg::MODE_ALLOC: begin
                        if (i_rd_data.kind == bct_pkg::KIND_FREE || r_cur == LAST) begin
                            n_state = bct_pkg::S_OUT;
                        end else begin
                            n_state = bct_pkg::S_RD;
                        end
                    end
                    bct_pkg::MODE_FREE_CHAIN: begin
                        // The walk only carries on through a link that stays in the table.
                        if (i_rd_data.kind != bct_pkg::KIND_LINK || !link_ok
                                || r_step == LAST) begin
                            n_state = bct_pkg::S_OUT;
                        end else begin
                            n_state = bct_pkg::S_RD;
                        end
                    end
                    default: n_state = bct_pkg::S_OUT;
                endcase
            end
            bct_pkg::S_OUT: begin
                if (i_m_tready) begin
                    n_state = bct_pkg::S_IDLE;
                end
            end
            default: n_state = bct_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cur       = r_cur;
        n_step      = r_step;
        n_res_block = r_res_block;
        n_res_kind  = r_res_kind;
        n_status    = r_status;
        n_freed     = r_freed;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cur;
        o_wr_data   = '0;
        case (r_state)
            bct_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_block = 6'd0;
                    n_res_kind  = bct_pkg::KIND_FREE;
                    n_status    = bct_pkg::ST_OK;
                    n_freed     = 7'd0;
                end
            end
            bct_pkg::S_EXEC: begin
                o_wr_addr = IW'(r_blk);
                case (r_mode)
                    bct_pkg::MODE_ALLOC: begin
                        n_cur = '0;
                    end
                    bct_pkg::MODE_LINK: begin
                        if (blk_ok && tgt_ok) begin
                            o_wr_en        = 1'b1;
                            o_wr_data.kind = bct_pkg::KIND_LINK;
                            o_wr_data.link = r_tgt;
                        end else begin
                            n_status = bct_pkg::ST_RANGE;
                        end
                    end
                    bct_pkg::MODE_MARK_END: begin
                        if (blk_ok) begin
                            o_wr_en        = 1'b1;
                            o_wr_data.kind = bct_pkg::KIND_END;
                        end else begin
                            n_status = bct_pkg::ST_RANGE;
                        end
                    end
                    bct_pkg::MODE_FREE: begin
                        if (blk_ok) begin
                            o_wr_en = 1'b1;
                        end else begin
                            n_status = bct_pkg::ST_RANGE;
                        end
                    end
                    bct_pkg::MODE_FREE_CHAIN,
                    bct_pkg::MODE_READ: begin
                        if (blk_ok) begin
                            n_cur  = IW'(r_blk);
                            n_step = '0;
                        end else begin
                            n_status = bct_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                        n_cur = r_cur;
                    end
                endcase
            end
            bct_pkg::S_EV: begin
                case (r_mode)
                    bct_pkg::MODE_ALLOC: begin
                        if (i_rd_data.kind == bct_pkg::KIND_FREE) begin
                            o_wr_en        = 1'b1;
                            o_wr_data.kind = bct_pkg::KIND_RESERVED;
                            n_res_block    = 6'(r_cur);
                        end else if (r_cur == LAST) begin
                            n_status = bct_pkg::ST_NO_FREE;
                        end else begin
                            n_cur = r_cur + 1'b1;
                        end
                    end
                    bct_pkg::MODE_READ: begin
                        n_res_kind  = i_rd_data.kind;
                        n_res_block = (i_rd_data.kind == bct_pkg::KIND_LINK)
                                      ? i_rd_data.link : 6'd0;
                    end
                    bct_pkg::MODE_FREE_CHAIN: begin
                        if (i_rd_data.kind != bct_pkg::KIND_FREE) begin
                            o_wr_en = 1'b1;
                            n_freed = r_freed + 1'b1;
                            n_cur   = IW'(i_rd_data.link);
                            n_step  = r_step + 1'b1;
                        end
                    end
                    default: begin
                        n_cur = r_cur;
                    end
                endcase
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= bct_pkg::t_mode'(i_s_tdata[2:0]);
            r_blk  <= i_s_tdata[10:3];
            r_tgt  <= i_s_tdata[16:11];
        end
        r_cur       <= n_cur;
        r_step      <= n_step;
        r_res_block <= n_res_block;
        r_res_kind  <= n_res_kind;
        r_status    <= n_status;
        r_freed     <= n_freed;
    end

endmodule

/* src/block_chain_allocation_table.sv */
// Link, mark end, free block and out-of-range items go from the execute state to the result.
// Read entry reads and evaluates its entry; allocate reads and evaluates entries from block 0 up
// to the first free one or the last. Free chain reads each chain entry and frees it unless free.
// A new item is taken only after the previous result is taken; a stalled result holds it off.
// Reset is synchronous, active low; the table then reads back its boot contents.
`include "block_chain_allocation_table_defines.svh"

module block_chain_allocation_table #(
    parameter int NUM_BLOCKS      = 64,
    parameter int RESERVED_BLOCKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[2:0], block_index[10:3], target_index[16:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result_block[5:0], result_kind[7:6], status[9:8],
                                   // freed_count[16:10]
);

    localparam int IW = $clog2(NUM_BLOCKS);

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    bct_pkg::t_entry wr_data;
    logic [IW-1:0]   rd_addr;
    bct_pkg::t_entry rd_data;

    logic            in_accept;
    logic            res_no_free;
    logic            res_range;
    logic            res_blk_zero;
    logic            res_low_zero;

    bct_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    bct_table #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_accept    = s_tvalid && s_tready;
    assign res_no_free  = m_tvalid && (m_tdata[9:8] == bct_pkg::ST_NO_FREE);
    assign res_range    = m_tvalid && (m_tdata[9:8] == bct_pkg::ST_RANGE);
    assign res_blk_zero = (m_tdata[5:0] == 6'd0) && (m_tdata[16:10] == 7'd0);
    assign res_low_zero = (m_tdata[7:0] == 8'd0) && (m_tdata[16:10] == 7'd0);

    `BCT_ASSERT_SAME(a_busy_while_result, i_clk, i_rst_n, m_tvalid, !s_tready)
    `BCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !s_tready && !m_tvalid)
    `BCT_ASSERT_SAME(a_no_free_clean, i_clk, i_rst_n, res_no_free, res_blk_zero)
    `BCT_ASSERT_SAME(a_range_clean, i_clk, i_rst_n, res_range, res_low_zero)

endmodule

/* verif/block_chain_allocation_table_tb.sv */
`timescale 1ns / 100ps

module block_chain_allocation_table_tb;

    localparam int NUM_BLOCKS      = 64;
    localparam int RESERVED_BLOCKS = 4;
    localparam int RANDOM_ITEMS    = 500;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 2 * NUM_BLOCKS + 20;
    localparam int REPORT_LIMIT    = 10;

    // Mode codes that the block leaves unused.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } t_ready_style;

    // Result fields as they sit in m_tdata[16:0], highest first.
    typedef struct packed {
        logic [6:0]       freed;
        bct_pkg::t_status status;
        bct_pkg::t_kind   kind;
        logic [5:0]       blk;
    } t_alloc_result;

    class alloc_table_scoreboard;
        bct_pkg::t_entry fat [NUM_BLOCKS];
        t_alloc_result   pending [$];
        t_alloc_result   last_pred;
        int              errors;

        function new();
            errors = 0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                fat[i].kind = (i < RESERVED_BLOCKS) ? bct_pkg::KIND_RESERVED
                                                    : bct_pkg::KIND_FREE;
                fat[i].link = 6'd0;
            end
        endfunction

        // Applies one accepted item to the shadow table and queues its result.
        function void note_request(logic [2:0] mode, logic [7:0] blk, logic [5:0] tgt);
            t_alloc_result   r;
            bct_pkg::t_entry e;
            bit              in_range;
            logic [5:0]      cur;
            int              i;
            r = '0;
            in_range = blk < NUM_BLOCKS;
            case (mode)
                bct_pkg::MODE_ALLOC: begin
                    r.status = bct_pkg::ST_NO_FREE;
                    for (i = 0; i < NUM_BLOCKS; i++) begin
                        if (fat[i].kind == bct_pkg::KIND_FREE) begin
                            fat[i] = '{kind: bct_pkg::KIND_RESERVED, link: 6'd0};
                            r.blk = 6'(i);
                            r.status = bct_pkg::ST_OK;
                            break;
                        end
                    end
                end
                bct_pkg::MODE_LINK: begin
                    if (!in_range || tgt >= NUM_BLOCKS) r.status = bct_pkg::ST_RANGE;
                    else fat[blk] = '{kind: bct_pkg::KIND_LINK, link: tgt};
                end
                bct_pkg::MODE_MARK_END: begin
                    if (!in_range) r.status = bct_pkg::ST_RANGE;
                    else fat[blk] = '{kind: bct_pkg::KIND_END, link: 6'd0};
                end
                bct_pkg::MODE_FREE: begin
                    if (!in_range) r.status = bct_pkg::ST_RANGE;
                    else fat[blk] = '{kind: bct_pkg::KIND_FREE, link: 6'd0};
                end
                bct_pkg::MODE_FREE_CHAIN: begin
                    if (!in_range) begin
                        r.status = bct_pkg::ST_RANGE;
                    end else begin
                        // The walk follows links only, and gives up at a free entry.
                        cur = blk[5:0];
                        for (i = 0; i < NUM_BLOCKS; i++) begin
                            e = fat[cur];
                            if (e.kind == bct_pkg::KIND_FREE) break;
                            fat[cur] = '{kind: bct_pkg::KIND_FREE, link: 6'd0};
                            r.freed = r.freed + 7'd1;
                            if (e.kind != bct_pkg::KIND_LINK) break;
                            cur = e.link;
                        end
                    end
                end
                bct_pkg::MODE_READ: begin
                    if (!in_range) begin
                        r.status = bct_pkg::ST_RANGE;
                    end else begin
                        r.kind = fat[blk].kind;
                        if (fat[blk].kind == bct_pkg::KIND_LINK) r.blk = fat[blk].link;
                    end
                end
                default: ;
            endcase
            last_pred = r;
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] data);
            t_alloc_result got;
            t_alloc_result want;
            got = t_alloc_result'(data[16:0]);
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: block %0d kind %0d status %0d freed %0d",
                             got.blk, got.kind, got.status, got.freed);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("mismatch, expected: block %0d kind %0d status %0d freed %0d",
                                 want.blk, want.kind, want.status, want.freed);
                        $display("          actual:   block %0d kind %0d status %0d freed %0d",
                                 got.blk, got.kind, got.status, got.freed);
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // mode[2:0], block_index[10:3], target_index[16:11]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // result_block[5:0], result_kind[7:6], status[9:8],
                                  // freed_count[16:10]

    alloc_table_scoreboard sb = new();

    int           burst_left  = 0;
    int           items_sent  = 0;
    int           idle_cycles = 0;
    int           ready_left  = 0;
    t_ready_style ready_style = READY_ALWAYS;

    block_chain_allocation_table #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // The receiver switches between steady, coin-toss and mostly stalled stretches.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_style <= t_ready_style'($urandom_range(0, 2));
            ready_left  <= $urandom_range(20, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_style)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("block_chain_allocation_table_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Ends the current burst with a gap of random length once it runs out.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_item(logic [2:0] mode, logic [7:0] blk, logic [5:0] tgt);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tgt, blk, mode};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        sb.note_request(mode, blk, tgt);
        items_sent++;
        pace();
    endtask

    task automatic run_directed();
        send_item(bct_pkg::MODE_READ, 8'd0, 6'd0);          // reserved boot block
        send_item(bct_pkg::MODE_READ, 8'd63, 6'd0);         // top block, free
        send_item(bct_pkg::MODE_ALLOC, 8'd0, 6'd0);
        send_item(bct_pkg::MODE_ALLOC, 8'd0, 6'd0);
        send_item(bct_pkg::MODE_LINK, 8'd4, 6'd5);
        send_item(bct_pkg::MODE_MARK_END, 8'd5, 6'd0);
        send_item(bct_pkg::MODE_READ, 8'd4, 6'd0);
        send_item(bct_pkg::MODE_READ, 8'd5, 6'd0);
        send_item(bct_pkg::MODE_FREE_CHAIN, 8'd4, 6'd0);
        send_item(bct_pkg::MODE_FREE_CHAIN, 8'd4, 6'd0);    // head already free
        send_item(bct_pkg::MODE_LINK, 8'd63, 6'd63);        // link into itself
        send_item(bct_pkg::MODE_FREE_CHAIN, 8'd63, 6'd0);
        send_item(bct_pkg::MODE_FREE_CHAIN, 8'd1, 6'd0);    // reserved head
        send_item(bct_pkg::MODE_ALLOC, 8'd0, 6'd0);
        send_item(bct_pkg::MODE_MARK_END, 8'd0, 6'd0);
        send_item(bct_pkg::MODE_FREE, 8'd0, 6'd0);
        send_item(bct_pkg::MODE_FREE, 8'd255, 6'd0);
        send_item(bct_pkg::MODE_FREE_CHAIN, 8'd64, 6'd0);
        send_item(bct_pkg::MODE_LINK, 8'd200, 6'd63);
        send_item(bct_pkg::MODE_READ, 8'd128, 6'd0);
        send_item(bct_pkg::MODE_MARK_END, 8'd64, 6'd0);
        send_item(MODE_SPARE_A, 8'd0, 6'd0);
        send_item(MODE_SPARE_B, 8'd255, 6'd63);
    endtask

    task automatic run_random();
        logic [5:0] blocks [$];
        logic [7:0] blk;
        int         start;
        int         pick;
        int         len;
        int         fills;
        int         long_chains;
        start = items_sent;
        fills = 0;
        long_chains = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // Allocate a few blocks, chain them, and usually free the chain.
                blocks.delete();
                len = $urandom_range(1, 8);
                repeat (len) begin
                    send_item(bct_pkg::MODE_ALLOC, 8'($urandom_range(0, 255)),
                              6'($urandom_range(0, 63)));
                    if (sb.last_pred.status == bct_pkg::ST_OK)
                        blocks.push_back(sb.last_pred.blk);
                end
                if (blocks.size() > 0) begin
                    for (int i = 0; i + 1 < blocks.size(); i++)
                        send_item(bct_pkg::MODE_LINK, {2'b00, blocks[i]}, blocks[i + 1]);
                    if ($urandom_range(0, 3) == 0)
                        send_item(bct_pkg::MODE_LINK, {2'b00, blocks[blocks.size() - 1]},
                                  blocks[0]);
                    else
                        send_item(bct_pkg::MODE_MARK_END, {2'b00, blocks[blocks.size() - 1]},
                                  6'd0);
                    if ($urandom_range(0, 1) == 0)
                        send_item(bct_pkg::MODE_READ,
                                  {2'b00, blocks[$urandom_range(0, blocks.size() - 1)]}, 6'd0);
                    if ($urandom_range(0, 4) != 0)
                        send_item(bct_pkg::MODE_FREE_CHAIN, {2'b00, blocks[0]}, 6'd0);
                end
            end else if (pick < 44 && long_chains < 2) begin
                // One chain through every block, so the walk runs its full length.
                long_chains++;
                for (int i = 0; i < NUM_BLOCKS - 1; i++)
                    send_item(bct_pkg::MODE_LINK, 8'(i), 6'(i + 1));
                send_item(bct_pkg::MODE_LINK, 8'(NUM_BLOCKS - 1), 6'($urandom_range(0, 63)));
                send_item(bct_pkg::MODE_FREE_CHAIN, 8'd0, 6'd0);
            end else if (pick < 48 && fills < 3) begin
                // Allocate until the table runs dry.
                fills++;
                do begin
                    send_item(bct_pkg::MODE_ALLOC, 8'd0, 6'd0);
                end while (sb.last_pred.status == bct_pkg::ST_OK);
                send_item(bct_pkg::MODE_ALLOC, 8'd0, 6'd0);
            end else begin
                blk = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, NUM_BLOCKS - 1))
                                                 : 8'($urandom_range(0, 255));
                send_item(3'($urandom_range(0, 7)), blk, 6'($urandom_range(0, 63)));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("block_chain_allocation_table_tb: done, clean");
        end else begin
            $display("block_chain_allocation_table_tb: done, errors");
        end
        $finish;
    end

endmodule
